[rtl/core/usi_pkg.sv]
`default_nettype none

package usi_pkg;

   // widths fixed by the record format
   localparam int unsigned OffsetBitsDefault = 40;
   localparam int unsigned RecOffsetW        = 40;
   localparam int unsigned NewlineW          = 32;
   localparam int unsigned IntervalW         = 25;
   localparam int unsigned CodePointW        = 21;

   localparam logic [IntervalW-1:0] IntervalReset = 25'd65536;

   // record kinds
   localparam logic RecCheckpoint = 1'b0;
   localparam logic RecSummary    = 1'b1;

   // byte classes
   localparam logic [7:0] LeadMask2 = 8'hE0;
   localparam logic [7:0] LeadTag2  = 8'hC0;
   localparam logic [7:0] LeadMask3 = 8'hF0;
   localparam logic [7:0] LeadTag3  = 8'hE0;
   localparam logic [7:0] LeadMask4 = 8'hF8;
   localparam logic [7:0] LeadTag4  = 8'hF0;
   localparam logic [7:0] ContMask  = 8'hC0;
   localparam logic [7:0] ContTag   = 8'h80;

   // code point limits
   localparam logic [CodePointW-1:0] SurrogateLo = 21'h00D800;
   localparam logic [CodePointW-1:0] SurrogateHi = 21'h00DFFF;
   localparam logic [CodePointW-1:0] CodePointMax = 21'h10FFFF;
   localparam logic [CodePointW-1:0] BmpMax      = 21'h00FFFF;
   localparam logic [CodePointW-1:0] Newline     = 21'h00000A;

   // record queue
   localparam int unsigned RecFifoDepth = 4;
   localparam int unsigned RecPtrW      = 2;
   localparam int unsigned RecCntW      = 3;

   typedef struct packed {
      logic                  record_kind;
      logic [RecOffsetW-1:0] byte_offset;
      logic [RecOffsetW-1:0] cu_offset;
      logic [NewlineW-1:0]   newline_count;
      logic                  text_valid;
      logic                  last_of_run;
   } usi_rec_type;

   // records written into the queue in the same cycle
   typedef struct packed {
      logic [1:0]  count;
      usi_rec_type first;
      usi_rec_type second;
   } usi_push_type;

   // low bits of an offset as carried in a record
   function automatic logic [RecOffsetW-1:0] rec_offset(input logic [63:0] value);
      return value[RecOffsetW-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/usi_req_if.sv]
`default_nettype none

interface usi_req_if;
   import usi_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

[rtl/core/usi_rsp_if.sv]
`default_nettype none

interface usi_rsp_if;
   import usi_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  record_kind;
   logic [RecOffsetW-1:0] byte_offset;
   logic [RecOffsetW-1:0] cu_offset;
   logic [NewlineW-1:0]   newline_count;
   logic                  text_valid;
   logic                  last_of_run;

   modport source (output valid, output record_kind, output byte_offset, output cu_offset,
                   output newline_count, output text_valid, output last_of_run,
                   input ready);
   modport sink   (input valid, input record_kind, input byte_offset, input cu_offset,
                   input newline_count, input text_valid, input last_of_run,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/usi_rec_fifo.sv]
`default_nettype none

module usi_rec_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  usi_pkg::usi_push_type push,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output usi_pkg::usi_rec_type  out_rec
);
   import usi_pkg::*;

   usi_rec_type        rec_mem_ff [RecFifoDepth];
   logic [RecPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RecPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RecCntW-1:0] count_ff, count_in;
   logic               pop;
   logic [RecPtrW-1:0] wr_ptr_next;

   // space for two records keeps a full beat from ever overflowing
   assign room      = (count_ff <= RecCntW'(RecFifoDepth - 2));
   assign out_valid = (count_ff != '0);
   assign out_rec   = rec_mem_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign wr_ptr_next = wr_ptr_ff + RecPtrW'(1);

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + RecPtrW'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RecPtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + RecCntW'(push.count) - RecCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // record storage, up to two writes a cycle
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         rec_mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         rec_mem_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

[rtl/core/utf8_scan_indexer_core.sv]
`default_nettype none
// output: each record goes into a four-entry record queue and is offered on rsp_if
// throughput: one byte per cycle while req_if.ready is high; a byte that causes
//    two records pushes both; records leave at one per cycle while rsp_if.ready is high
// req_if.ready drops only while that queue holds more than two records
// reset (synchronous, active high) clears all text state and empties the queue;
//    the checkpoint interval returns to 65536

module utf8_scan_indexer_core #(
   parameter int unsigned OFFSET_BITS = usi_pkg::OffsetBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [usi_pkg::IntervalW-1:0]  csr_wr_data,
   usi_req_if.sink                        req_if,
   usi_rsp_if.source                      rsp_if
);
   import usi_pkg::*;

   localparam int unsigned CmpW = (OFFSET_BITS > IntervalW) ? OFFSET_BITS : IntervalW;

   // text state
   logic [IntervalW-1:0]   interval_ff;
   logic [1:0]             pend_ff, pend_in;
   logic [CodePointW-1:0]  partial_ff, partial_in;
   logic [2:0]             seq_len_ff, seq_len_in;
   logic [OFFSET_BITS-1:0] bp_ff, bp_in;
   logic [OFFSET_BITS-1:0] dist_ff, dist_in;
   logic [OFFSET_BITS-1:0] cu_ff, cu_in;
   logic [NewlineW-1:0]    nl_ff, nl_in;
   logic                   failed_ff, failed_in;

   // decode signals
   logic                   accept;
   logic [7:0]             b;
   logic                   done;
   logic                   good;
   logic [CodePointW-1:0]  cp;
   logic [1:0]             dec_pend;
   logic [CodePointW-1:0]  dec_partial;
   logic [2:0]             dec_seq_len;
   logic                   dec_failed;
   logic [2:0]             code_len;

   // counter signals
   logic [OFFSET_BITS:0]   bp_sum;
   logic [OFFSET_BITS-1:0] bp_new;
   logic [2:0]             bp_delta;
   logic [OFFSET_BITS-1:0] dist_sum;
   logic [1:0]             cu_units;
   logic [OFFSET_BITS:0]   cu_sum;
   logic [OFFSET_BITS-1:0] cu_new;
   logic [NewlineW-1:0]    nl_new;
   logic                   ckpt;
   logic [OFFSET_BITS-1:0] bp_rec, cu_rec;
   logic [NewlineW-1:0]    nl_rec;
   logic                   summary_valid;

   usi_rec_type            ckpt_rec, sum_rec, out_rec;
   usi_push_type           push;
   logic                   room;
   logic                   out_valid;

   assign accept = req_if.valid & req_if.ready;
   assign b      = req_if.data_byte;

   // byte decode: lead or continuation
   always_comb begin
      dec_pend    = pend_ff;
      dec_partial = partial_ff;
      dec_seq_len = seq_len_ff;
      dec_failed  = failed_ff;
      done        = 1'b0;
      good        = 1'b0;
      cp          = '0;
      code_len    = (pend_ff == 2'd0) ? 3'd1 : seq_len_ff;
      if (!failed_ff) begin
         if (pend_ff == 2'd0) begin
            if (!b[7]) begin
               cp          = CodePointW'(b);
               dec_seq_len = 3'd1;
               done        = 1'b1;
            end else if ((b & LeadMask2) == LeadTag2) begin
               dec_partial = CodePointW'(b[4:0]);
               dec_pend    = 2'd1;
               dec_seq_len = 3'd2;
            end else if ((b & LeadMask3) == LeadTag3) begin
               dec_partial = CodePointW'(b[3:0]);
               dec_pend    = 2'd2;
               dec_seq_len = 3'd3;
            end else if ((b & LeadMask4) == LeadTag4) begin
               dec_partial = CodePointW'(b[2:0]);
               dec_pend    = 2'd3;
               dec_seq_len = 3'd4;
            end else begin
               dec_failed = 1'b1;
            end
         end else if ((b & ContMask) != ContTag) begin
            dec_failed = 1'b1;
         end else begin
            dec_partial = {partial_ff[CodePointW-7:0], b[5:0]};
            dec_pend    = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               cp   = dec_partial;
               done = 1'b1;
            end
         end
         // finished code point: reject surrogates and values past the last plane
         if (done) begin
            dec_partial = '0;
            dec_seq_len = 3'd0;
            if ((cp >= SurrogateLo && cp <= SurrogateHi) || cp > CodePointMax) begin
               dec_failed = 1'b1;
            end else begin
               good = 1'b1;
            end
         end
      end
   end

   // saturating byte count and distance since the last checkpoint
   always_comb begin
      bp_sum   = {1'b0, bp_ff} + (OFFSET_BITS+1)'(code_len);
      bp_new   = bp_sum[OFFSET_BITS] ? '1 : bp_sum[OFFSET_BITS-1:0];
      bp_delta = bp_sum[OFFSET_BITS] ? ~bp_ff[2:0] : code_len;
      dist_sum = dist_ff + OFFSET_BITS'(bp_delta);
      ckpt     = good && (CmpW'(dist_sum) >= CmpW'(interval_ff));
   end

   // saturating code unit and newline counts
   always_comb begin
      cu_units = (cp > BmpMax) ? 2'd2 : 2'd1;
      cu_sum   = {1'b0, cu_ff} + (OFFSET_BITS+1)'(cu_units);
      cu_new   = cu_sum[OFFSET_BITS] ? '1 : cu_sum[OFFSET_BITS-1:0];
      nl_new   = (cp == Newline && nl_ff != '1) ? nl_ff + NewlineW'(1) : nl_ff;
   end

   // values after this byte, before an end-of-text clear
   always_comb begin
      bp_rec        = good ? bp_new : bp_ff;
      cu_rec        = good ? cu_new : cu_ff;
      nl_rec        = good ? nl_new : nl_ff;
      summary_valid = !dec_failed && (dec_pend == 2'd0);
   end

   // next state; the last byte of a text starts the next one from zero
   always_comb begin
      if (req_if.end_of_text) begin
         pend_in    = '0;
         partial_in = '0;
         seq_len_in = '0;
         bp_in      = '0;
         dist_in    = '0;
         cu_in      = '0;
         nl_in      = '0;
         failed_in  = 1'b0;
      end else begin
         pend_in    = dec_pend;
         partial_in = dec_partial;
         seq_len_in = dec_seq_len;
         bp_in      = bp_rec;
         dist_in    = ckpt ? '0 : (good ? dist_sum : dist_ff);
         cu_in      = cu_rec;
         nl_in      = nl_rec;
         failed_in  = dec_failed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         partial_ff <= '0;
         seq_len_ff <= '0;
         bp_ff      <= '0;
         dist_ff    <= '0;
         cu_ff      <= '0;
         nl_ff      <= '0;
         failed_ff  <= 1'b0;
      end else if (accept) begin
         pend_ff    <= pend_in;
         partial_ff <= partial_in;
         seq_len_ff <= seq_len_in;
         bp_ff      <= bp_in;
         dist_ff    <= dist_in;
         cu_ff      <= cu_in;
         nl_ff      <= nl_in;
         failed_ff  <= failed_in;
      end
   end

   // checkpoint interval register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= IntervalReset;
      end else if (csr_wr_en) begin
         interval_ff <= csr_wr_data;
      end
   end

   // records for this beat: checkpoint first, then summary
   always_comb begin
      ckpt_rec.record_kind   = RecCheckpoint;
      ckpt_rec.byte_offset   = rec_offset(64'(bp_rec));
      ckpt_rec.cu_offset     = rec_offset(64'(cu_rec));
      ckpt_rec.newline_count = '0;
      ckpt_rec.text_valid    = 1'b0;
      ckpt_rec.last_of_run   = !req_if.end_of_text;

      sum_rec.record_kind    = RecSummary;
      sum_rec.byte_offset    = rec_offset(64'(bp_rec));
      sum_rec.cu_offset      = rec_offset(64'(cu_rec));
      sum_rec.newline_count  = nl_rec;
      sum_rec.text_valid     = summary_valid;
      sum_rec.last_of_run    = 1'b1;

      push.count  = accept ? (2'(ckpt) + 2'(req_if.end_of_text)) : 2'd0;
      push.first  = ckpt ? ckpt_rec : sum_rec;
      push.second = sum_rec;
   end

   usi_rec_fifo u_rec_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (out_valid),
      .out_ready (rsp_if.ready),
      .out_rec   (out_rec)
   );

   // channel ports
   assign req_if.ready         = room;
   assign rsp_if.valid         = out_valid;
   assign rsp_if.record_kind   = out_rec.record_kind;
   assign rsp_if.byte_offset   = out_rec.byte_offset;
   assign rsp_if.cu_offset     = out_rec.cu_offset;
   assign rsp_if.newline_count = out_rec.newline_count;
   assign rsp_if.text_valid    = out_rec.text_valid;
   assign rsp_if.last_of_run   = out_rec.last_of_run;

endmodule

`default_nettype wire
